// ===== src/psc_pkg.sv =====
package psc_pkg;

  // Fixed field widths of the point and result items.
  localparam int COORD_BITS = 16;
  localparam int REMOVED_BITS = 17;
  localparam int DEFAULT_MAX_POINTS = 65536;

  // Result queue: room for one waiting result plus the largest burst of three.
  localparam int MAX_BURST = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_BITS = 2;
  localparam int QCNT_BITS = 3;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         pen_move;
    logic                         list_end;
  } point_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic                         out_move;
    logic                         burst_last;
    logic                         list_done;
    logic [REMOVED_BITS-1:0]      removed_count;
  } result_t;

  // Burst of results produced by one point, in output order.
  typedef struct packed {
    logic [1:0]                 count;
    result_t [MAX_BURST-1:0]    r;
  } push_t;

endpackage

// ===== src/psc_core.sv =====
module psc_core import psc_pkg::*; #(
  parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   point_valid,
  input  point_t point,
  output logic   point_stall,
  input  logic   room,
  output push_t  push
);

  localparam int CNT_BITS = $clog2(MAX_POINTS + 1);
  localparam int SUM_BITS = CNT_BITS + 2;
  localparam int CMP_BITS = (CNT_BITS > REMOVED_BITS) ? CNT_BITS : REMOVED_BITS;

  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_ONE   = 2'd1,
    PH_RUN   = 2'd2
  } phase_t;

  // Input register.
  logic   hold_valid;
  point_t hold;

  // Run state.
  phase_t                       phase;
  logic signed [COORD_BITS-1:0] start_x, start_y, prev_x, prev_y;
  logic                         start_move, prev_move;
  logic signed [COORD_BITS:0]   run_dx, run_dy;
  logic                         start_is_prev, first_written;
  logic [CNT_BITS-1:0]          points_in, points_out;

  logic                         fire;
  logic                         is_first, brk, fw_end;
  logic signed [COORD_BITS:0]   dx, dy;
  logic [CNT_BITS-1:0]          pin_next, pout_base, pout_next;
  logic [SUM_BITS-1:0]          pout_sum;
  logic [CNT_BITS-1:0]          diff;
  logic [CMP_BITS-1:0]          diff_wide;
  logic [REMOVED_BITS-1:0]      removed;
  logic [1:0]                   n;
  result_t [MAX_BURST-1:0]      r;

  // The input register is held while the result queue lacks room for a burst.
  assign point_stall = hold_valid & ~room;
  assign fire = hold_valid & room;

  // Steps from the previous point, exact at one bit wider than the coordinates.
  assign dx = {hold.point_x[COORD_BITS-1], hold.point_x} - {prev_x[COORD_BITS-1], prev_x};
  assign dy = {hold.point_y[COORD_BITS-1], hold.point_y} - {prev_y[COORD_BITS-1], prev_y};

  always_comb begin
    case (phase)
      PH_ONE:  is_first = 1'b0;
      PH_RUN:  is_first = 1'b0;
      default: is_first = 1'b1;
    endcase
  end

  assign brk = (phase == PH_RUN) &&
               ((dx != run_dx) || (dy != run_dy) || hold.pen_move);
  assign fw_end = first_written | brk;

  // Build the burst of results for the point in the input register.
  always_comb begin
    r = '0;
    n = 2'd0;
    if (brk) begin
      r[n].out_x = start_x;
      r[n].out_y = start_y;
      r[n].out_move = start_move;
      n = n + 2'd1;
      if (!start_is_prev) begin
        r[n].out_x = prev_x;
        r[n].out_y = prev_y;
        r[n].out_move = prev_move;
        n = n + 2'd1;
      end
    end
    if (hold.list_end) begin
      if (!fw_end && !is_first) begin
        r[n].out_x = start_x;
        r[n].out_y = start_y;
        r[n].out_move = start_move;
        n = n + 2'd1;
      end
      r[n].out_x = hold.point_x;
      r[n].out_y = hold.point_y;
      r[n].out_move = hold.pen_move;
      n = n + 2'd1;
    end
    if (n != 2'd0) begin
      r[n - 2'd1].burst_last = 1'b1;
      if (hold.list_end) begin
        r[n - 2'd1].list_done = 1'b1;
        r[n - 2'd1].removed_count = removed;
      end
    end
  end

  // Point counters saturate at the list limit.
  always_comb begin
    if (is_first) begin
      pin_next = CNT_BITS'(1);
      pout_base = '0;
    end else begin
      pin_next = (points_in < CNT_BITS'(MAX_POINTS)) ? points_in + CNT_BITS'(1) : points_in;
      pout_base = points_out;
    end
    pout_sum = SUM_BITS'(pout_base) + SUM_BITS'(n);
    pout_next = (pout_sum > SUM_BITS'(MAX_POINTS)) ? CNT_BITS'(MAX_POINTS)
                                                   : pout_sum[CNT_BITS-1:0];
    diff = (pin_next > pout_next) ? pin_next - pout_next : '0;
    diff_wide = CMP_BITS'(diff);
    removed = (diff_wide > CMP_BITS'({REMOVED_BITS{1'b1}})) ? {REMOVED_BITS{1'b1}}
                                                            : diff_wide[REMOVED_BITS-1:0];
  end

  assign push.count = fire ? n : 2'd0;
  assign push.r = r;

  // Input register and run state.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      phase <= PH_FIRST;
      start_x <= '0;
      start_y <= '0;
      start_move <= 1'b0;
      prev_x <= '0;
      prev_y <= '0;
      prev_move <= 1'b0;
      run_dx <= '0;
      run_dy <= '0;
      start_is_prev <= 1'b0;
      first_written <= 1'b0;
      points_in <= '0;
      points_out <= '0;
    end else begin
      if (point_valid && !point_stall) begin
        hold_valid <= 1'b1;
      end else if (fire) begin
        hold_valid <= 1'b0;
      end
      if (fire) begin
        if (hold.list_end) begin
          phase <= PH_FIRST;
          start_x <= '0;
          start_y <= '0;
          start_move <= 1'b0;
          prev_x <= '0;
          prev_y <= '0;
          prev_move <= 1'b0;
          run_dx <= '0;
          run_dy <= '0;
          start_is_prev <= 1'b0;
          first_written <= 1'b0;
          points_in <= '0;
          points_out <= '0;
        end else begin
          prev_x <= hold.point_x;
          prev_y <= hold.point_y;
          prev_move <= hold.pen_move;
          points_in <= pin_next;
          points_out <= pout_next;
          if (is_first) begin
            start_x <= hold.point_x;
            start_y <= hold.point_y;
            start_move <= hold.pen_move;
            start_is_prev <= 1'b1;
            first_written <= 1'b0;
            phase <= PH_ONE;
          end else if (phase == PH_ONE) begin
            run_dx <= dx;
            run_dy <= dy;
            start_is_prev <= 1'b0;
            phase <= PH_RUN;
          end else if (brk) begin
            first_written <= 1'b1;
            start_x <= hold.point_x;
            start_y <= hold.point_y;
            start_move <= hold.pen_move;
            start_is_prev <= 1'b1;
            run_dx <= dx;
            run_dy <= dy;
          end else begin
            start_is_prev <= 1'b0;
          end
        end
      end
    end
  end

  // The input register takes a new point whenever it is not held.
  always_ff @(posedge clk) begin
    if (point_valid && !point_stall) begin
      hold <= point;
    end
  end

endmodule

// ===== src/psc_queue.sv =====
module psc_queue import psc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    room,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  result_t [QUEUE_DEPTH-1:0] mem;
  logic [PTR_BITS-1:0]       wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0]      count;
  logic                      pop;

  assign result_valid = (count != '0);
  assign result = mem[rd_ptr];
  assign pop = result_valid & ~result_stall;

  // A full burst fits only while at most one result waits.
  assign room = (count <= QCNT_BITS'(QUEUE_DEPTH - MAX_BURST));

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_BITS'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      count <= count + QCNT_BITS'(push.count) - QCNT_BITS'(pop);
    end
  end

  // Burst entries are written to consecutive free slots.
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_BURST; k++) begin
      if (k < int'(push.count)) begin
        mem[wr_ptr + PTR_BITS'(k)] <= push.r[k];
      end
    end
  end

endmodule

// ===== src/polyline_step_compactor.sv =====
// Removes the interior points of straight runs of equal steps from a stream
// of plot points and reports on the final result of each list how many
// points were dropped. A point enters an input register and is processed
// there once the result queue has room; its results (none, one, two or
// three) go into a four-entry result queue. A new point is accepted every
// cycle as long as each point causes at most one result and the output is
// not stalled; a point that causes k results puts k entries before the
// single output port, and the input holds while more than one result
// waits in the queue. Lists up to MAX_POINTS points are counted exactly;
// longer lists saturate the counters.
module polyline_step_compactor import psc_pkg::*; #(
  parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    point_valid,
  output logic    point_stall,
  input  point_t  point,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  push_t push;
  logic  room;

  // Run tracking and result generation.
  psc_core #(
    .MAX_POINTS(MAX_POINTS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .point_valid(point_valid),
    .point      (point),
    .point_stall(point_stall),
    .room       (room),
    .push       (push)
  );

  // Result queue toward the output channel.
  psc_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .room        (room),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule
